FILE: hw/rtl/cmof_pkg.sv
package cmof_pkg;

	localparam int CMOF_MAX_JETS = 16;

	localparam int COORD_W = 14;
	localparam int SQ_W    = 2 * COORD_W;
	localparam int RAD_W   = 30;
	localparam int EN_W    = 16;
	localparam int CNT_W   = 16;
	localparam int NUM_CNT = 7;
	localparam int APB_AW  = 5;

	localparam int S_TDATA_W = ((3 * COORD_W + EN_W - COORD_W + 7) / 8) * 8;
	localparam int S_TUSER_W = 4;
	localparam int M_TDATA_W = ((4 + NUM_CNT * CNT_W + 7) / 8) * 8;
	localparam int M_TUSER_W = 2;

	// counter slots, in the order they go out on the summary beat
	localparam int CNT_TOWER_MATCHED = 0;
	localparam int CNT_TOWER_KEPT    = 1;
	localparam int CNT_TRACK_MATCHED = 2;
	localparam int CNT_TRACK_KEPT    = 3;
	localparam int CNT_PART_MATCHED  = 4;
	localparam int CNT_PART_MIDDLE   = 5;
	localparam int CNT_PART_KEPT     = 6;

	localparam logic [RAD_W-1:0] CONE_RADIUS_SQ_RST = RAD_W'(1048576);
	localparam logic [EN_W-1:0]  TOWER_THR_RST      = EN_W'(320);
	localparam logic [EN_W-1:0]  TRACK_THR_RST      = EN_W'(800);
	localparam logic [EN_W-1:0]  PART_MID_THR_RST   = EN_W'(1600);
	localparam logic [EN_W-1:0]  PART_KEEP_THR_RST  = EN_W'(5600);

	typedef enum logic [2:0] {
		REG_CONE_RADIUS_SQ = 3'd0,
		REG_TOWER_THR      = 3'd1,
		REG_TRACK_THR      = 3'd2,
		REG_PART_MID_THR   = 3'd3,
		REG_PART_KEEP_THR  = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		ACT_LOAD = 2'd0,
		ACT_TEST = 2'd1,
		ACT_END  = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		KIND_TOWER    = 2'd0,
		KIND_TRACK    = 2'd1,
		KIND_PARTICLE = 2'd2,
		KIND_NONE     = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		RES_ACK     = 2'd0,
		RES_VERDICT = 2'd1,
		RES_SUMMARY = 2'd2
	} res_kind_t;

	typedef struct packed {
		logic wr_en;
		logic start;
	} cone_req_t;

	typedef struct packed {
		logic done;
		logic hit;
	} cone_sts_t;

endpackage

FILE: hw/rtl/cone_match_object_filter_unit.sv
// channel     dir  handshake                     payload
// s_axis      in   tvalid / tready               tuser action, kind; tdata eta, phi, energy
// m_axis      out  tvalid / tready               tuser result kind; tdata flags, counters
// apb         in   psel, penable, pwrite, pready five registers at 0x00..0x10
//
// a jet load or end of event goes to emit, which fills the output register when free
// object tests pass scan, update, emit; no scan with an empty store or unknown kind:
// the shared subtract, square and compare pipeline visits one stored jet axis per cycle
// s_axis_tready is low from accept until the result enters the output register, so a
// held output beat stalls the input only once the next item has finished
// arst_n clears counters, the jet count and the sequencer; the axis store is not cleared
module cone_match_object_filter_unit import cmof_pkg::*; #(
	parameter int MAX_JETS = CMOF_MAX_JETS,
	localparam int AW = (MAX_JETS > 1) ? $clog2(MAX_JETS) : 1,
	localparam int CW = $clog2(MAX_JETS + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// eta [13:0], phi [27:14], energy [43:28], zero fill
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// action [1:0], object_kind [3:2]
	input  logic [S_TUSER_W-1:0] s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// matched [0], above_middle [1], kept [2], jet_dropped [3], tower_matched_count,
	// tower_kept_count, track_matched_count, track_kept_count, particle_matched_count,
	// particle_middle_count, particle_kept_count (16 bits each from bit 4), zero fill
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	// result_kind [1:0]
	output logic [M_TUSER_W-1:0] m_axis_tuser,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [APB_AW-1:0]    paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_UPDATE = 4'b0100,
		ST_EMIT   = 4'b1000
	} state_t;

	state_t state_q;

	logic [RAD_W-1:0] radius_sq_q;
	logic [EN_W-1:0]  tower_thr_q;
	logic [EN_W-1:0]  track_thr_q;
	logic [EN_W-1:0]  part_mid_thr_q;
	logic [EN_W-1:0]  part_keep_thr_q;

	logic signed [COORD_W-1:0] obj_eta_q;
	logic signed [COORD_W-1:0] obj_phi_q;
	logic [EN_W-1:0]  energy_q;
	kind_t            kind_q;
	res_kind_t        res_kind_q;
	logic             matched_q;
	logic             mid_q;
	logic             keep_q;
	logic             dropped_q;
	logic [CW-1:0]    jets_loaded_q;
	logic [CNT_W-1:0] cnt_q [NUM_CNT];

	logic                 m_valid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [M_TUSER_W-1:0] m_tuser_q;

	logic                      in_beat;
	action_t                   in_action;
	kind_t                     in_kind;
	logic signed [COORD_W-1:0] in_eta;
	logic signed [COORD_W-1:0] in_phi;
	logic [EN_W-1:0]           in_energy;
	logic                      store_full;
	logic                      cfg_wr;
	reg_idx_t                  cfg_idx;
	logic                      out_load;
	logic                      upd_mid;
	logic                      upd_keep;
	logic [NUM_CNT-1:0]        bump;
	logic [M_TDATA_W-1:0]      out_data;
	cone_req_t                 cone_req;
	cone_sts_t                 cone_sts;

	assign in_beat    = s_axis_tvalid && s_axis_tready;
	assign in_action  = action_t'(s_axis_tuser[1:0]);
	assign in_kind    = kind_t'(s_axis_tuser[3:2]);
	assign in_eta     = s_axis_tdata[COORD_W-1:0];
	assign in_phi     = s_axis_tdata[2*COORD_W-1:COORD_W];
	assign in_energy  = s_axis_tdata[2*COORD_W+EN_W-1:2*COORD_W];
	assign store_full = (jets_loaded_q == CW'(MAX_JETS));

	assign s_axis_tready = (state_q == ST_IDLE);
	assign out_load      = (state_q == ST_EMIT) && (!m_valid_q || m_axis_tready);

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			REG_CONE_RADIUS_SQ: prdata = 32'(radius_sq_q);
			REG_TOWER_THR:      prdata = 32'(tower_thr_q);
			REG_TRACK_THR:      prdata = 32'(track_thr_q);
			REG_PART_MID_THR:   prdata = 32'(part_mid_thr_q);
			REG_PART_KEEP_THR:  prdata = 32'(part_keep_thr_q);
			default:            prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_sq_q     <= CONE_RADIUS_SQ_RST;
			tower_thr_q     <= TOWER_THR_RST;
			track_thr_q     <= TRACK_THR_RST;
			part_mid_thr_q  <= PART_MID_THR_RST;
			part_keep_thr_q <= PART_KEEP_THR_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_CONE_RADIUS_SQ: radius_sq_q     <= pwdata[RAD_W-1:0];
				REG_TOWER_THR:      tower_thr_q     <= pwdata[EN_W-1:0];
				REG_TRACK_THR:      track_thr_q     <= pwdata[EN_W-1:0];
				REG_PART_MID_THR:   part_mid_thr_q  <= pwdata[EN_W-1:0];
				REG_PART_KEEP_THR:  part_keep_thr_q <= pwdata[EN_W-1:0];
				default: ;
			endcase
		end
	end

	// shared distance unit
	assign cone_req.wr_en = in_beat && (in_action == ACT_LOAD) && !store_full;
	assign cone_req.start = in_beat && (in_action == ACT_TEST) && (in_kind != KIND_NONE)
		&& (jets_loaded_q != '0);

	cmof_cone_unit #(
		.MAX_JETS(MAX_JETS)
	) u_cone (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (cone_req),
		.wr_addr   (jets_loaded_q[AW-1:0]),
		.jet_eta   (in_eta),
		.jet_phi   (in_phi),
		.obj_eta   (obj_eta_q),
		.obj_phi   (obj_phi_q),
		.jet_count (jets_loaded_q),
		.radius_sq (radius_sq_q),
		.sts       (cone_sts)
	);

	// verdict flags and counter bumps from the match result
	always_comb begin
		upd_mid  = 1'b0;
		upd_keep = 1'b0;
		bump     = '0;
		if (matched_q) begin
			unique case (kind_q)
				KIND_TOWER: begin
					upd_keep = energy_q > tower_thr_q;
					bump[CNT_TOWER_MATCHED] = 1'b1;
					bump[CNT_TOWER_KEPT]    = upd_keep;
				end
				KIND_TRACK: begin
					upd_keep = energy_q > track_thr_q;
					bump[CNT_TRACK_MATCHED] = 1'b1;
					bump[CNT_TRACK_KEPT]    = upd_keep;
				end
				KIND_PARTICLE: begin
					upd_mid  = energy_q > part_mid_thr_q;
					upd_keep = upd_mid && (energy_q > part_keep_thr_q);
					bump[CNT_PART_MATCHED] = 1'b1;
					bump[CNT_PART_MIDDLE]  = upd_mid;
					bump[CNT_PART_KEPT]    = upd_keep;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		out_data    = '0;
		out_data[0] = matched_q;
		out_data[1] = mid_q;
		out_data[2] = keep_q;
		out_data[3] = dropped_q;
		if (res_kind_q == RES_SUMMARY) begin
			for (int k = 0; k < NUM_CNT; k++) begin
				out_data[4 + k*CNT_W +: CNT_W] = cnt_q[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			obj_eta_q <= in_eta;
			obj_phi_q <= in_phi;
			energy_q  <= in_energy;
			kind_q    <= in_kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			res_kind_q    <= RES_ACK;
			matched_q     <= 1'b0;
			mid_q         <= 1'b0;
			keep_q        <= 1'b0;
			dropped_q     <= 1'b0;
			jets_loaded_q <= '0;
			for (int k = 0; k < NUM_CNT; k++) begin
				cnt_q[k] <= '0;
			end
			m_valid_q <= 1'b0;
			m_tdata_q <= '0;
			m_tuser_q <= '0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
				m_tdata_q <= out_data;
				m_tuser_q <= res_kind_q;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						matched_q <= 1'b0;
						mid_q     <= 1'b0;
						keep_q    <= 1'b0;
						dropped_q <= 1'b0;
						unique case (in_action)
							ACT_LOAD: begin
								res_kind_q <= RES_ACK;
								dropped_q  <= store_full;
								if (!store_full) begin
									jets_loaded_q <= jets_loaded_q + CW'(1);
								end
								state_q <= ST_EMIT;
							end
							ACT_TEST: begin
								res_kind_q <= RES_VERDICT;
								// nothing to scan: verdict goes straight to update
								state_q <= cone_req.start ? ST_SCAN : ST_UPDATE;
							end
							ACT_END: begin
								res_kind_q <= RES_SUMMARY;
								state_q    <= ST_EMIT;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (cone_sts.done) begin
						matched_q <= cone_sts.hit;
						state_q   <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					mid_q  <= upd_mid;
					keep_q <= upd_keep;
					for (int k = 0; k < NUM_CNT; k++) begin
						if (bump[k] && (cnt_q[k] != '1)) begin
							cnt_q[k] <= cnt_q[k] + CNT_W'(1);
						end
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_load) begin
						if (res_kind_q == RES_SUMMARY) begin
							for (int k = 0; k < NUM_CNT; k++) begin
								cnt_q[k] <= '0;
							end
							jets_loaded_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_jets_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		jets_loaded_q <= CW'(MAX_JETS))
		else $error("jet count beyond store depth");

	a_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cone_sts.done |-> (state_q == ST_SCAN))
		else $error("distance unit finished outside a scan");

	a_flags_need_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> ((!m_tdata_q[2] && !m_tdata_q[1]) || m_tdata_q[0]))
		else $error("kept or middle without a match");

	a_summary_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && (res_kind_q == RES_SUMMARY)) |=>
			((jets_loaded_q == '0) && (cnt_q[CNT_TOWER_MATCHED] == '0)
			&& (cnt_q[CNT_PART_KEPT] == '0)))
		else $error("event state not cleared after summary");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !cone_req.start && !cone_req.wr_en)
		else $error("distance unit request while busy");

endmodule

FILE: hw/rtl/cmof_cone_unit.sv
module cmof_cone_unit import cmof_pkg::*; #(
	parameter int MAX_JETS = CMOF_MAX_JETS,
	localparam int AW = (MAX_JETS > 1) ? $clog2(MAX_JETS) : 1,
	localparam int CW = $clog2(MAX_JETS + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cone_req_t                 req,
	input  logic [AW-1:0]             wr_addr,
	input  logic signed [COORD_W-1:0] jet_eta,
	input  logic signed [COORD_W-1:0] jet_phi,
	input  logic signed [COORD_W-1:0] obj_eta,
	input  logic signed [COORD_W-1:0] obj_phi,
	input  logic [CW-1:0]             jet_count,
	input  logic [RAD_W-1:0]          radius_sq,
	output cone_sts_t                 sts
);

	logic signed [COORD_W-1:0] mem_eta [MAX_JETS];
	logic signed [COORD_W-1:0] mem_phi [MAX_JETS];

	logic              active_q;
	logic              issuing_q;
	logic [CW-1:0]     rd_idx_q;
	logic              hit_q;
	logic              v_s1;
	logic              v_s2;
	logic signed [COORD_W-1:0] eta_s1;
	logic signed [COORD_W-1:0] phi_s1;
	logic [SQ_W-1:0]   sq_eta_s2;
	logic [SQ_W-1:0]   sq_phi_s2;

	logic signed [COORD_W:0]     de_eta;
	logic signed [COORD_W:0]     de_phi;
	logic signed [2*COORD_W+1:0] prod_eta;
	logic signed [2*COORD_W+1:0] prod_phi;
	logic [SQ_W:0]               dist_sq;
	logic [CW-1:0]               rd_idx_nxt;
	logic                        done;

	assign de_eta   = {obj_eta[COORD_W-1], obj_eta} - {eta_s1[COORD_W-1], eta_s1};
	assign de_phi   = {obj_phi[COORD_W-1], obj_phi} - {phi_s1[COORD_W-1], phi_s1};
	assign prod_eta = de_eta * de_eta;
	assign prod_phi = de_phi * de_phi;
	assign dist_sq  = {1'b0, sq_eta_s2} + {1'b0, sq_phi_s2};
	assign rd_idx_nxt = rd_idx_q + CW'(1);
	assign done     = active_q && !issuing_q && !v_s1 && !v_s2;

	assign sts.done = done;
	assign sts.hit  = hit_q;

	// jet axis store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_eta[wr_addr] <= jet_eta;
			mem_phi[wr_addr] <= jet_phi;
		end
		eta_s1 <= mem_eta[rd_idx_q[AW-1:0]];
		phi_s1 <= mem_phi[rd_idx_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		sq_eta_s2 <= prod_eta[SQ_W-1:0];
		sq_phi_s2 <= prod_phi[SQ_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			issuing_q <= 1'b0;
			rd_idx_q  <= '0;
			hit_q     <= 1'b0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
		end else begin
			v_s1 <= issuing_q;
			v_s2 <= v_s1;
			if (req.start) begin
				active_q  <= 1'b1;
				issuing_q <= 1'b1;
				rd_idx_q  <= '0;
				hit_q     <= 1'b0;
			end else begin
				if (issuing_q) begin
					rd_idx_q <= rd_idx_nxt;
					if (rd_idx_nxt == jet_count) begin
						issuing_q <= 1'b0;
					end
				end
				if (v_s2 && ({{(RAD_W-SQ_W-1){1'b0}}, dist_sq} < radius_sq)) begin
					hit_q <= 1'b1;
				end
				if (done) begin
					active_q <= 1'b0;
				end
			end
		end
	end

endmodule
